### rtl/ctb_pkg.sv
// ----------------------------------------------------------------------------
// ctb_pkg: shared types and constants of the tonal color balance block
// Register indexes, tone weight bundle and fixed-point ramp constants.
// ----------------------------------------------------------------------------
package ctb_pkg;

  typedef enum logic [1:0] {
    CFG_RED   = 2'd0,
    CFG_GREEN = 2'd1,
    CFG_BLUE  = 2'd2,
    CFG_KEEP  = 2'd3
  } cfg_idx_e;

  localparam int unsigned CORR_W = 48;
  localparam int unsigned WGT_W  = 17;

  typedef logic [CORR_W-1:0] corr_t;

  typedef struct packed {
    logic [WGT_W-1:0] ws;
    logic [WGT_W-1:0] wm;
    logic [WGT_W-1:0] wh;
  } tone_w_t;

  localparam logic signed [19:0] SHADOW_EDGE = 20'sd120062;
  localparam logic signed [19:0] MID_LOW     = 20'sd54526;
  localparam logic signed [19:0] MID_HIGH    = 20'sd207618;
  localparam logic signed [19:0] HIGH_EDGE   = 20'sd142082;
  localparam logic signed [19:0] Q16_ONE     = 20'sd65536;
  localparam logic signed [16:0] SCALE_Q16   = 17'sd45875;

  function automatic logic [WGT_W-1:0] clamp_q16(input logic signed [19:0] v);
    logic [WGT_W-1:0] r;
    if (v < 20'sd0) begin
      r = '0;
    end else if (v > Q16_ONE) begin
      r = Q16_ONE[WGT_W-1:0];
    end else begin
      r = v[WGT_W-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/ctb_tone.sv
// ----------------------------------------------------------------------------
// ctb_tone: lightness and tone weights
// Three stages: max+min, scaled lightness, then shadow/midtone/highlight weights.
// ----------------------------------------------------------------------------
module ctb_tone #(
  parameter int unsigned CB = 16
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [2:0][CB-1:0] pix_i,
  output logic [2:0][CB-1:0] pix_o,
  output logic [CB:0]        s0_o,
  output ctb_pkg::tone_w_t   w_o
);
  import ctb_pkg::*;

  localparam int unsigned XW = 19;
  localparam int unsigned NW = CB + 18;
  localparam int unsigned UW = ((CB > 18) ? CB : 18) + 2;
  localparam logic [CB-1:0] M = '1;

  logic [CB-1:0]        mx, mn;
  logic [2:0][CB-1:0]   pa_q, pb_q, pc_q;
  logic [CB:0]          sa_q, sb_q, sc_q;
  logic [NW-1:0]        nn;
  logic [UW-1:0]        u;
  logic [XW-1:0]        xa, xb_q;
  logic signed [19:0]   xs;
  logic [WGT_W-1:0]     ma, mb;
  logic [2*WGT_W-1:0]   mp;
  tone_w_t              w_d, w_q;

  always_comb begin
    mx = pix_i[0];
    mn = pix_i[0];
    for (int i = 1; i < 3; i++) begin
      if (pix_i[i] > mx) mx = pix_i[i];
      if (pix_i[i] < mn) mn = pix_i[i];
    end
  end

  always_comb begin
    nn = {sa_q, 17'd0} + NW'(M >> 1);
    u  = UW'(nn[NW-1:CB]) + UW'(nn[CB-1:0]);
    xa = XW'(nn[NW-1:CB]);
    for (int k = 0; k < 2; k++) begin
      xa = xa + XW'(u >> CB);
      u  = UW'(u >> CB) + UW'(u[CB-1:0]);
    end
    if (u >= UW'(M)) xa = xa + 1'b1;
  end

  always_comb begin
    xs     = $signed({1'b0, xb_q});
    ma     = clamp_q16(xs - MID_LOW);
    mb     = clamp_q16(MID_HIGH - xs);
    mp     = ma * mb;
    w_d.ws = clamp_q16(SHADOW_EDGE - xs);
    w_d.wm = WGT_W'((mp + (2*WGT_W)'(32768)) >> 16);
    w_d.wh = clamp_q16(xs - HIGH_EDGE);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q <= pix_i;
      sa_q <= {1'b0, mx} + {1'b0, mn};
      pb_q <= pa_q;
      sb_q <= sa_q;
      xb_q <= xa;
      pc_q <= pb_q;
      sc_q <= sb_q;
      w_q  <= w_d;
    end
  end

  assign pix_o = pc_q;
  assign s0_o  = sc_q;
  assign w_o   = w_q;

endmodule

### rtl/ctb_chan.sv
// ----------------------------------------------------------------------------
// ctb_chan: per-channel tone correction
// Four stages: weighted products, sum, 0.7 scale, component offset and clamp.
// ----------------------------------------------------------------------------
module ctb_chan #(
  parameter int unsigned CB = 16
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [CB-1:0]    c_i,
  input  ctb_pkg::corr_t   corr_i,
  input  ctb_pkg::tone_w_t w_i,
  output logic [CB-1:0]    n_o
);
  import ctb_pkg::*;

  localparam int unsigned TW = 32 + CB;
  localparam logic [CB-1:0] M = '1;
  localparam logic signed [TW-1:0] MS = TW'(M);

  logic signed [2:0][33:0] pd_q;
  logic signed [35:0]      se_q;
  logic signed [52:0]      pf;
  logic signed [30:0]      qf_q;
  logic [CB-1:0]           cd_q, ce_q, cf_q;
  logic signed [TW-1:0]    tq, tr, tv;
  logic [CB-1:0]           n_d, n_q;

  always_comb begin
    pf = 53'(se_q) * 53'(SCALE_Q16);
    tq = (TW'(qf_q) <<< CB) - TW'(qf_q);
    tr = (tq + (TW'(1) <<< 23)) >>> 24;
    tv = tr + TW'($signed({1'b0, cf_q}));
    if (tv < TW'(0)) begin
      n_d = '0;
    end else if (tv > MS) begin
      n_d = M;
    end else begin
      n_d = tv[CB-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pd_q[0] <= 34'($signed(corr_i[15:0])) * 34'($signed({1'b0, w_i.ws}));
      pd_q[1] <= 34'($signed(corr_i[31:16])) * 34'($signed({1'b0, w_i.wm}));
      pd_q[2] <= 34'($signed(corr_i[47:32])) * 34'($signed({1'b0, w_i.wh}));
      cd_q    <= c_i;
      se_q    <= 36'($signed(pd_q[0])) + 36'($signed(pd_q[1])) + 36'($signed(pd_q[2]));
      ce_q    <= cd_q;
      qf_q    <= 31'((pf + 53'sd2097152) >>> 22);
      cf_q    <= ce_q;
      n_q     <= n_d;
    end
  end

  assign n_o = n_q;

endmodule

### rtl/ctb_div.sv
// ----------------------------------------------------------------------------
// ctb_div: pipelined restoring divider
// One quotient bit per stage; the quotient is known to fit in QB bits.
// ----------------------------------------------------------------------------
module ctb_div #(
  parameter int unsigned NW = 34,
  parameter int unsigned DW = 17,
  parameter int unsigned QB = 17
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QB-1:0] quo_o
);

  logic [QB-1:0][DW-1:0] rem_q, rem_d, rem_in;
  logic [QB-1:0][QB-1:0] lo_q, lo_d, lo_in;
  logic [QB-1:0][QB-1:0] q_q, q_d, q_in;
  logic [QB-1:0][DW-1:0] den_q, den_in;

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [DW:0] tr;
    logic        ge;

    if (k == 0) begin : g_first
      assign rem_in[k] = num_i[NW-1:QB];
      assign lo_in[k]  = num_i[QB-1:0];
      assign q_in[k]   = '0;
      assign den_in[k] = den_i;
    end else begin : g_next
      assign rem_in[k] = rem_q[k-1];
      assign lo_in[k]  = lo_q[k-1];
      assign q_in[k]   = q_q[k-1];
      assign den_in[k] = den_q[k-1];
    end

    always_comb begin
      tr       = {rem_in[k], lo_in[k][QB-1]};
      ge       = (tr >= {1'b0, den_in[k]});
      rem_d[k] = ge ? DW'(tr - {1'b0, den_in[k]}) : tr[DW-1:0];
      lo_d[k]  = lo_in[k] << 1;
      q_d[k]   = {q_in[k][QB-2:0], ge};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d[k];
        lo_q[k]  <= lo_d[k];
        q_q[k]   <= q_d[k];
        den_q[k] <= den_in[k];
      end
    end
  end

  assign quo_o = q_q[QB-1];

endmodule

### rtl/ctb_light.sv
// ----------------------------------------------------------------------------
// ctb_light: lightness restore
// Spread and numerators, then a divider per channel and the final selection.
// ----------------------------------------------------------------------------
module ctb_light #(
  parameter int unsigned CB = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               keep_i,
  input  logic [2:0][CB-1:0] n_i,
  input  logic [CB:0]        s0_i,
  output logic [2:0][CB-1:0] o_o
);

  localparam int unsigned QB = CB + 1;
  localparam int unsigned NW = 2 * CB + 2;
  localparam int unsigned DW = CB + 1;
  localparam int unsigned SW = 2 * CB + 4;
  localparam logic [CB-1:0] M = '1;

  logic [CB-1:0]                nmx, nmn, d, dd, a, grey;
  logic [CB:0]                  sm, dev;
  logic [2:0][CB+1:0]           df;
  logic [2:0][CB-1:0]           nh_q, ni_q;
  logic [CB:0]                  s0h_q;
  logic [CB-1:0]                ddh_q, ah_q, gh_q, gi_q;
  logic [2:0][CB+1:0]           dfh_q;
  logic                         dzh_q, dzi_q;
  logic signed [2:0][SW-1:0]    num;
  logic [2:0][NW-1:0]           numi_q;
  logic [DW-1:0]                deni_q;
  logic [2:0][QB-1:0]           quo;
  logic [QB-1:0][2:0][CB-1:0]   nd_q;
  logic [QB-1:0][CB-1:0]        gd_q;
  logic [QB-1:0]                dzd_q;
  logic [2:0][CB-1:0]           o_d, o_q;

  always_comb begin
    nmx = n_i[0];
    nmn = n_i[0];
    for (int i = 1; i < 3; i++) begin
      if (n_i[i] > nmx) nmx = n_i[i];
      if (n_i[i] < nmn) nmn = n_i[i];
    end
    d    = nmx - nmn;
    sm   = {1'b0, nmx} + {1'b0, nmn};
    dd   = (sm <= {1'b0, M}) ? sm[CB-1:0] : CB'({M, 1'b0} - sm);
    dev  = (s0_i >= {1'b0, M}) ? (s0_i - {1'b0, M}) : ({1'b0, M} - s0_i);
    a    = CB'({1'b0, M} - dev);
    grey = CB'((s0_i + 1'b1) >> 1);
    for (int i = 0; i < 3; i++) begin
      df[i] = ({2'b00, CB'(n_i[i] - nmn)} << 1) - {2'b00, d};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = SW'($signed({1'b0, s0h_q})) * SW'($signed({1'b0, ddh_q}))
             + SW'($signed({1'b0, ah_q})) * SW'($signed(dfh_q[i]));
      if ($signed(num[i]) < SW'(0)) num[i] = '0;
      num[i] = num[i] + SW'($signed({1'b0, ddh_q}));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nh_q   <= n_i;
      s0h_q  <= s0_i;
      ddh_q  <= dd;
      ah_q   <= a;
      gh_q   <= grey;
      dfh_q  <= df;
      dzh_q  <= (d == '0);
      ni_q   <= nh_q;
      gi_q   <= gh_q;
      dzi_q  <= dzh_q;
      deni_q <= {ddh_q, 1'b0};
      for (int i = 0; i < 3; i++) begin
        numi_q[i] <= num[i][NW-1:0];
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_div
    ctb_div #(
      .NW(NW),
      .DW(DW),
      .QB(QB)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en_i),
      .num_i (numi_q[c]),
      .den_i (deni_q),
      .quo_o (quo[c])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nd_q[0]  <= ni_q;
      gd_q[0]  <= gi_q;
      dzd_q[0] <= dzi_q;
      for (int k = 1; k < QB; k++) begin
        nd_q[k]  <= nd_q[k-1];
        gd_q[k]  <= gd_q[k-1];
        dzd_q[k] <= dzd_q[k-1];
      end
      o_q <= o_d;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!keep_i) begin
        o_d[i] = nd_q[QB-1][i];
      end else if (dzd_q[QB-1]) begin
        o_d[i] = gd_q[QB-1];
      end else if (quo[i] > {1'b0, M}) begin
        o_d[i] = M;
      end else begin
        o_d[i] = quo[i][CB-1:0];
      end
    end
  end

  assign o_o = o_q;

  a_grey_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && keep_i && dzd_q[QB-1]) |=> (o_q[0] == o_q[1] && o_q[1] == o_q[2]))
    else $error("grey pixel with lightness restore gave unequal channels");

endmodule

### rtl/tonal_color_balance.sv
// ----------------------------------------------------------------------------
// tonal_color_balance: shadow/midtone/highlight color balance on RGBA pixels
// Pixels enter on the slave stream and leave on the master stream, one
// transaction per pixel. Corrections and the keep-lightness flag are set
// through the plain write port while the stream is idle, which only the user
// ensures. The pipeline has three stages of lightness and tone weights, four
// of channel correction, two of spread and numerators, one per quotient bit in
// the lightness divider and one output stage. It takes one pixel per cycle
// while the receiver is ready; the whole pipeline advances on a single enable.
// When the receiver stalls with a valid result on the output, every stage
// holds and s_axis_tready drops, so nothing is lost or repeated. Reset empties
// the pipeline and clears all correction registers to zero.
// ----------------------------------------------------------------------------
module tonal_color_balance #(
  parameter int unsigned COMPONENT_BITS = 16,
  localparam int unsigned TDW = ((4 * COMPONENT_BITS + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [TDW-1:0]         s_axis_tdata,  // red, green, blue, alpha
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [TDW-1:0]         m_axis_tdata,  // out_red, out_green, out_blue, out_alpha
  output logic                   m_axis_tlast,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [ctb_pkg::CORR_W-1:0] cfg_data_i
);
  import ctb_pkg::*;

  localparam int unsigned CB  = COMPONENT_BITS;
  localparam int unsigned LAT = CB + 11;
  localparam int unsigned PRE = 7;

  corr_t                     corr_q [3];
  logic                      keep_q;
  logic [LAT-1:0]            vld_q;
  logic [LAT-1:0][CB-1:0]    ad_q;
  logic [LAT-1:0]            ld_q;
  logic                      en;
  logic [2:0][CB-1:0]        pix_in, pix_c, n_g, o_fin;
  logic [CB:0]               s0_c;
  logic [3:0][CB:0]          s0d_q;
  tone_w_t                   w_c;

  assign en            = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corr_q[0] <= '0;
      corr_q[1] <= '0;
      corr_q[2] <= '0;
      keep_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_RED:   corr_q[0] <= cfg_data_i;
        CFG_GREEN: corr_q[1] <= cfg_data_i;
        CFG_BLUE:  corr_q[2] <= cfg_data_i;
        CFG_KEEP:  keep_q    <= cfg_data_i[0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ad_q  <= {ad_q[LAT-2:0], s_axis_tdata[4*CB-1:3*CB]};
      ld_q  <= {ld_q[LAT-2:0], s_axis_tlast};
      s0d_q <= {s0d_q[2:0], s0_c};
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_pix
    assign pix_in[c] = s_axis_tdata[c*CB +: CB];
  end

  ctb_tone #(.CB(CB)) u_tone (
    .clk_i (clk_i),
    .en_i  (en),
    .pix_i (pix_in),
    .pix_o (pix_c),
    .s0_o  (s0_c),
    .w_o   (w_c)
  );

  for (genvar c = 0; c < 3; c++) begin : g_chan
    ctb_chan #(.CB(CB)) u_chan (
      .clk_i  (clk_i),
      .en_i   (en),
      .c_i    (pix_c[c]),
      .corr_i (corr_q[c]),
      .w_i    (w_c),
      .n_o    (n_g[c])
    );
  end

  ctb_light #(.CB(CB)) u_light (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .keep_i (keep_q),
    .n_i    (n_g),
    .s0_i   (s0d_q[3]),
    .o_o    (o_fin)
  );

  assign m_axis_tdata = TDW'({ad_q[LAT-1], o_fin[2], o_fin[1], o_fin[0]});
  assign m_axis_tlast = ld_q[LAT-1];

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline occupancy changed during a stall");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q == '0) |-> s_axis_tready)
    else $error("empty pipeline refused a transaction");

  a_mid_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && vld_q[PRE-1]) |=> vld_q[PRE])
    else $error("item lost between correction and lightness stages");

endmodule

### tb/tonal_color_balance_checker.sv
// ----------------------------------------------------------------------------
// tonal_color_balance_checker: scoreboard for the tonal color balance block
// Follows register writes and accepted input pixels, predicts each balanced
// pixel in fixed point and compares every output transaction in order.
// ----------------------------------------------------------------------------
module tonal_color_balance_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  input  logic                       s_axis_tready,
  input  logic [63:0]                s_axis_tdata,
  input  logic                       s_axis_tlast,
  input  logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  input  logic [63:0]                m_axis_tdata,
  input  logic                       m_axis_tlast,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [ctb_pkg::CORR_W-1:0] cfg_data_i,
  output int                         fail_count_o,
  output int                         pending_o,
  output int                         checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ctb_pkg::*;

  localparam longint CMAX = 65535;

  typedef struct packed {
    logic        last;
    logic [15:0] alpha;
    logic [15:0] blue;
    logic [15:0] green;
    logic [15:0] red;
  } pixel_t;

  corr_t  red_corr, green_corr, blue_corr;
  logic   keep_light;
  pixel_t balanced_q[$];

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint round_shr(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint shift_of(corr_t r, int pos);
    logic signed [15:0] f;
    f = r[16*pos +: 16];
    return longint'(f);
  endfunction

  function automatic longint balance_chan(longint c, corr_t r, longint ws, longint wm,
                                          longint wh);
    longint acc, q, delta;
    acc   = shift_of(r, 0) * ws + shift_of(r, 1) * wm + shift_of(r, 2) * wh;
    q     = round_shr(acc * 45875, 22);
    delta = round_shr(q * CMAX, 24);
    return clip(c + delta, 0, CMAX);
  endfunction

  function automatic pixel_t balance_pixel(pixel_t p);
    longint c[3], n[3];
    longint mx, mn, s0, x, ws, wm, wh, nmx, nmn, d, dd, a, num;
    pixel_t r;
    c[0] = p.red;
    c[1] = p.green;
    c[2] = p.blue;
    mx = c[0];
    mn = c[0];
    for (int i = 1; i < 3; i++) begin
      if (c[i] > mx) mx = c[i];
      if (c[i] < mn) mn = c[i];
    end
    s0 = mx + mn;
    x  = (s0 * 131072 + CMAX / 2) / CMAX;
    ws = clip(120062 - x, 0, 65536);
    wm = (clip(x - 54526, 0, 65536) * clip(207618 - x, 0, 65536) + 32768) >>> 16;
    wh = clip(x - 142082, 0, 65536);
    n[0] = balance_chan(c[0], red_corr, ws, wm, wh);
    n[1] = balance_chan(c[1], green_corr, ws, wm, wh);
    n[2] = balance_chan(c[2], blue_corr, ws, wm, wh);
    if (keep_light) begin
      nmx = n[0];
      nmn = n[0];
      for (int i = 1; i < 3; i++) begin
        if (n[i] > nmx) nmx = n[i];
        if (n[i] < nmn) nmn = n[i];
      end
      d  = nmx - nmn;
      dd = (nmx + nmn <= CMAX) ? nmx + nmn : 2 * CMAX - (nmx + nmn);
      a  = CMAX - ((s0 > CMAX) ? s0 - CMAX : CMAX - s0);
      for (int i = 0; i < 3; i++) begin
        if (d == 0 || dd <= 0) begin
          n[i] = (s0 + 1) / 2;
        end else begin
          num = s0 * dd + a * (2 * (n[i] - nmn) - d);
          if (num < 0) num = 0;
          n[i] = clip((num + dd) / (2 * dd), 0, CMAX);
        end
      end
    end
    r.red   = n[0][15:0];
    r.green = n[1][15:0];
    r.blue  = n[2][15:0];
    r.alpha = p.alpha;
    r.last  = p.last;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t got, want;
    if (!rst_ni) begin
      red_corr     <= '0;
      green_corr   <= '0;
      blue_corr    <= '0;
      keep_light   <= 1'b0;
      fail_count_o <= 0;
      checked_o    <= 0;
      balanced_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        balanced_q.push_back(balance_pixel({s_axis_tlast, s_axis_tdata}));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tlast, m_axis_tdata};
        if (balanced_q.size() == 0) begin
          $display("[%0t] output transaction with no pixel pending", $time);
          fail_count_o++;
        end else begin
          want = balanced_q.pop_front();
          checked_o++;
          if (got.red != want.red) report_mismatch("red", got.red, want.red);
          if (got.green != want.green) report_mismatch("green", got.green, want.green);
          if (got.blue != want.blue) report_mismatch("blue", got.blue, want.blue);
          if (got.alpha != want.alpha) report_mismatch("alpha", got.alpha, want.alpha);
          if (got.last != want.last) begin
            report_mismatch("last", 16'(got.last), 16'(want.last));
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_RED:   red_corr   <= cfg_data_i;
          CFG_GREEN: green_corr <= cfg_data_i;
          CFG_BLUE:  blue_corr  <= cfg_data_i;
          CFG_KEEP:  keep_light <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  assign pending_o = balanced_q.size();

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the tonal color balance block
// Runs directed and random pixels under several correction settings, with
// bursty input and a stalling receiver; a checker scores every output.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ctb_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  corr_t       cfg_data_i = '0;

  int fail_count, pending, checked;
  int burst_left = 0;
  int settings_run = 0;
  int stall_mode = 0;
  longint cycle = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  tonal_color_balance DUT (.*);

  tonal_color_balance_checker u_checker (
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked), .*
  );

  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle > 400000) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (cycle % 300 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready <= ($urandom_range(0, 9) < 3);
      default: m_axis_tready <= (cycle % 7 < 4);
    endcase
  end

  task automatic send_pixel(logic [15:0] r, g, b, a, logic last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {a, b, g, r};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, corr_t value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic apply_setting(corr_t rc, corr_t gc, corr_t bc, logic keep);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    wait (pending == 0);
    repeat (40) @(negedge clk_i);
    write_reg(CFG_RED, rc);
    write_reg(CFG_GREEN, gc);
    write_reg(CFG_BLUE, bc);
    write_reg(CFG_KEEP, CORR_W'({$urandom, $urandom} & ~64'd1 | 64'(keep)));
    settings_run++;
  endtask

  function automatic corr_t rand_corr();
    return CORR_W'({$urandom, $urandom});
  endfunction

  task automatic random_pixels(int count);
    logic [15:0] r, g, b, base;
    for (int i = 0; i < count; i++) begin
      r = 16'($urandom);
      g = 16'($urandom);
      b = 16'($urandom);
      case ($urandom_range(0, 5))
        0: begin
          g = r;
          b = r;
        end
        1: begin
          base = 16'($urandom);
          r = base + 16'($urandom_range(0, 300));
          g = base;
          b = base - 16'($urandom_range(0, 300));
        end
        2: begin
          r = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          b = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end
        default: ;
      endcase
      send_pixel(r, g, b, 16'($urandom), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_pixel(16'h8000, 16'h8000, 16'h8000, 16'h1234, 1'b0);

    apply_setting(48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 48'h4000_C000_2000, 1'b1);
    send_pixel(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b1);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
    send_pixel(16'hFFFF, 16'h0000, 16'h0000, 16'hAAAA, 1'b0);
    send_pixel(16'h0000, 16'hFFFF, 16'h0000, 16'h5555, 1'b1);
    send_pixel(16'h0000, 16'h0000, 16'hFFFF, 16'h0001, 1'b0);
    send_pixel(16'h5555, 16'h5555, 16'h5555, 16'h8000, 1'b0);
    send_pixel(16'hAAAA, 16'hAAAA, 16'hAAAA, 16'h7FFF, 1'b1);
    send_pixel(16'h3400, 16'h3400, 16'h3400, 16'h0000, 1'b0);
    send_pixel(16'h7600, 16'h7600, 16'h7600, 16'h0000, 1'b0);
    send_pixel(16'hAB00, 16'hAB00, 16'hAB00, 16'h0000, 1'b0);
    send_pixel(16'hE000, 16'hE000, 16'hE000, 16'h0000, 1'b1);

    apply_setting(48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF, 48'h8000_7FFF_8000, 1'b0);
    send_pixel(16'hFFFF, 16'h0000, 16'h8000, 16'hFFFF, 1'b1);
    send_pixel(16'h0000, 16'hFFFF, 16'h8000, 16'h0000, 1'b0);
    send_pixel(16'h1000, 16'h1000, 16'h1000, 16'h0000, 1'b0);
    send_pixel(16'hF000, 16'hF000, 16'hF000, 16'h0000, 1'b1);
    random_pixels(150);

    apply_setting(48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 1'b1);
    random_pixels(150);
    apply_setting('0, '0, '0, 1'b0);
    random_pixels(100);
    for (int k = 0; k < 6; k++) begin
      apply_setting(rand_corr(), rand_corr(), rand_corr(), k[0]);
      random_pixels(130);
    end

    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (40) @(negedge clk_i);
    $display("Checked %0d balanced pixels across %0d correction settings,", checked,
             settings_run + 1);
    $display("with and without lightness restore, under bursty input and output stalls.");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### sim.f
rtl/ctb_pkg.sv
rtl/ctb_tone.sv
rtl/ctb_chan.sv
rtl/ctb_div.sv
rtl/ctb_light.sv
rtl/tonal_color_balance.sv
tb/tonal_color_balance_checker.sv
tb/tb_top.sv
